// ===== design/fcdma_pkg.sv =====
// shared types and codes for the four-channel dma controller
// no dependencies; used by the top level and by the port checker

package fcdma_pkg;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_addr;
        logic [7:0] wdata;
        logic [1:0] channel;
        logic       fdc_request;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] bus_address;
        logic [7:0]  rdata;
        logic [1:0]  fdc_tc;
    } t_out_item;

    // item opcodes
    localparam logic [1:0] OP_REG_WR  = 2'd0;
    localparam logic [1:0] OP_REG_RD  = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;
    localparam logic [1:0] OP_RETURN  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_READ_DATA  = 3'd0;
    localparam logic [2:0] KIND_NOTHING    = 3'd1;
    localparam logic [2:0] KIND_WRITE_DONE = 3'd2;
    localparam logic [2:0] KIND_MEM_READ   = 3'd3;
    localparam logic [2:0] KIND_MEM_WRITE  = 3'd4;
    localparam logic [2:0] KIND_FDC_WRITE  = 3'd5;
    localparam logic [2:0] KIND_FDC_READ   = 3'd6;
    localparam logic [2:0] KIND_BUSY       = 3'd7;

    // floppy terminal count codes
    localparam logic [1:0] TC_NONE    = 2'd0;
    localparam logic [1:0] TC_ASSERT  = 2'd1;
    localparam logic [1:0] TC_RELEASE = 2'd2;

    // channel-3 transfer type, mode bits 3..2
    localparam logic [1:0] MODE_VERIFY     = 2'd0;
    localparam logic [1:0] MODE_MEM_TO_FDC = 2'd1;
    localparam logic [1:0] MODE_FDC_TO_MEM = 2'd2;

    // register addresses above the address/count pairs
    localparam logic [3:0] REG_COMMAND  = 4'd8;
    localparam logic [3:0] REG_REQUEST  = 4'd9;
    localparam logic [3:0] REG_SGL_MASK = 4'd10;
    localparam logic [3:0] REG_MODE     = 4'd11;
    localparam logic [3:0] REG_CLR_FF   = 4'd12;
    localparam logic [3:0] REG_MCLR     = 4'd13;
    localparam logic [3:0] REG_CLR_MASK = 4'd14;
    localparam logic [3:0] REG_ALL_MASK = 4'd15;

endpackage

// ===== design/four_channel_dma_controller.sv =====
// four-channel dma controller top level
// depends on fcdma_pkg; per-channel state lives in a memory with a registered read

// Takes one item per clock while o_stall is low and returns exactly one result
// for each item. In an item's read step the per-channel record of the channel
// it touches (base and current address, base and current count, mode) is read
// from the channel memory; in its update step the record is updated and
// written back and the result is loaded into the output register. A write-back
// to the channel that the next item reads is forwarded, so items follow each
// other with no gap. The output register holds a result while the far side
// stalls; the input is stalled only when both the output register and the
// update stage are full. Channel records start out as zero through per-entry
// valid bits, so no clearing pass is needed after reset.
module four_channel_dma_controller #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  fcdma_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output fcdma_pkg::t_out_item o_data
);

    localparam int CH_W = $clog2(NUM_CHANNELS);

    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_M2M_SRC = 2'd1;
    localparam logic [1:0] PEND_FDC2MEM = 2'd2;
    localparam logic [1:0] PEND_MEM2FDC = 2'd3;

    typedef struct packed {
        logic [15:0] base_a;
        logic [15:0] cur_a;
        logic [15:0] base_c;
        logic [15:0] cur_c;
        logic [7:0]  mode;
    } t_chan_rec;

    // channel memory and its read side
    t_chan_rec              r_mem [NUM_CHANNELS];
    t_chan_rec              r_rd;
    t_chan_rec              r_fwd;
    logic                   r_fwd_hit;
    logic                   r_rd_ok;
    logic [NUM_CHANNELS-1:0] r_ent_vld;

    // update stage
    logic                   r_s1_valid;
    fcdma_pkg::t_in_item    r_s1;
    logic [CH_W-1:0]        r_s1_ch;

    // shared registers
    logic [7:0] r_command, n_command;
    logic [7:0] r_status, n_status;
    logic [7:0] r_temp, n_temp;
    logic [3:0] r_mask, n_mask;
    logic       r_request, n_request;
    logic       r_bptr, n_bptr;
    logic [1:0] r_pend, n_pend;
    logic [CH_W-1:0] r_pend_ch, n_pend_ch;

    logic                 r_out_valid;
    fcdma_pkg::t_out_item r_out, n_out;

    t_chan_rec       rec, n_rec;
    logic            accept, s1_fire;
    logic [CH_W-1:0] rd_ch;
    logic [CH_W-1:0] ret_ch;
    logic [3:0]      done_nib;

    function automatic logic [15:0] put_byte(input logic [15:0] w, input logic hi,
                                             input logic [7:0] v);
        put_byte = hi ? {v, w[7:0]} : {w[15:8], v};
    endfunction

    function automatic logic [15:0] step_addr(input logic [15:0] a, input logic [7:0] m);
        step_addr = m[5] ? a - 16'd1 : a + 16'd1;
    endfunction

    // one counted transfer; terminal count when the count wraps past zero
    function automatic t_chan_rec count_rec(input t_chan_rec r);
        t_chan_rec c;
        c = r;
        c.cur_a = step_addr(r.cur_a, r.mode);
        c.cur_c = r.cur_c - 16'd1;
        if (r.cur_c == 16'h0000 && r.mode[4]) begin
            c.cur_a = r.base_a;
            c.cur_c = r.base_c;
        end
        count_rec = c;
    endfunction

    assign s1_fire = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // a return reads the channel left pending by the item now completing
    assign ret_ch = r_s1_valid ? n_pend_ch : r_pend_ch;

    always_comb begin
        case (i_data.opcode)
            fcdma_pkg::OP_REG_WR:
                rd_ch = (i_data.reg_addr == fcdma_pkg::REG_MODE) ?
                        i_data.wdata[CH_W-1:0] : i_data.reg_addr[CH_W:1];
            fcdma_pkg::OP_REG_RD:  rd_ch = i_data.reg_addr[CH_W:1];
            fcdma_pkg::OP_SERVICE: rd_ch = i_data.channel[CH_W-1:0];
            default:               rd_ch = ret_ch;
        endcase
    end

    assign rec = r_fwd_hit ? r_fwd : (r_rd_ok ? r_rd : '0);
    assign done_nib = r_status[7:4];

    always_comb begin
        n_rec     = rec;
        n_command = r_command;
        n_status  = r_status;
        n_temp    = r_temp;
        n_mask    = r_mask;
        n_request = r_request;
        n_bptr    = r_bptr;
        n_pend    = r_pend;
        n_pend_ch = r_pend_ch;
        n_out     = '{kind: fcdma_pkg::KIND_NOTHING, bus_address: 16'h0000,
                      rdata: 8'h00, fdc_tc: fcdma_pkg::TC_NONE};

        case (r_s1.opcode)
            fcdma_pkg::OP_REG_WR: begin
                n_out.kind = fcdma_pkg::KIND_WRITE_DONE;
                if (!r_s1.reg_addr[3]) begin
                    n_bptr = !r_bptr;
                    if (r_s1.reg_addr[0]) begin
                        n_rec.base_c = put_byte(rec.base_c, r_bptr, r_s1.wdata);
                        n_rec.cur_c  = n_rec.base_c;
                    end else begin
                        n_rec.base_a = put_byte(rec.base_a, r_bptr, r_s1.wdata);
                        n_rec.cur_a  = n_rec.base_a;
                    end
                end else begin
                    case (r_s1.reg_addr)
                        fcdma_pkg::REG_COMMAND: n_command = r_s1.wdata;
                        fcdma_pkg::REG_REQUEST: n_request = r_s1.wdata[0];
                        fcdma_pkg::REG_SGL_MASK:
                            n_mask[r_s1.wdata[1:0]] = r_s1.wdata[2];
                        fcdma_pkg::REG_MODE:   n_rec.mode = r_s1.wdata;
                        fcdma_pkg::REG_CLR_FF: n_bptr = 1'b0;
                        fcdma_pkg::REG_MCLR: begin
                            n_bptr    = 1'b0;
                            n_command = 8'h00;
                            n_status  = 8'h00;
                            n_request = 1'b0;
                            n_temp    = 8'h00;
                            n_mask    = 4'hF;
                        end
                        fcdma_pkg::REG_CLR_MASK: n_mask = 4'h0;
                        default:                 n_mask = r_s1.wdata[3:0];
                    endcase
                end
            end
            fcdma_pkg::OP_REG_RD: begin
                n_out.kind = fcdma_pkg::KIND_READ_DATA;
                if (!r_s1.reg_addr[3]) begin
                    n_bptr = !r_bptr;
                    if (r_s1.reg_addr[0])
                        n_out.rdata = r_bptr ? rec.cur_c[15:8] : rec.cur_c[7:0];
                    else
                        n_out.rdata = r_bptr ? rec.cur_a[15:8] : rec.cur_a[7:0];
                end else if (r_s1.reg_addr == fcdma_pkg::REG_COMMAND) begin
                    // status shares the command address on reads
                    n_out.rdata  = r_status;
                    n_status     = {4'h0, r_status[3:0]};
                    n_out.fdc_tc = fcdma_pkg::TC_RELEASE;
                end else if (r_s1.reg_addr == fcdma_pkg::REG_MCLR) begin
                    n_out.rdata = r_temp;
                end else begin
                    n_out.rdata = 8'hFF;
                end
            end
            fcdma_pkg::OP_SERVICE: begin
                if (r_pend != PEND_NONE) begin
                    n_out.kind = fcdma_pkg::KIND_BUSY;
                end else if (r_command[2] || r_mask[r_s1_ch] || done_nib[r_s1_ch]) begin
                    n_out.kind = fcdma_pkg::KIND_NOTHING;
                end else if (r_request && r_command[0] && r_s1_ch == CH_W'(0)) begin
                    n_out.kind        = fcdma_pkg::KIND_MEM_READ;
                    n_out.bus_address = rec.cur_a;
                    n_pend            = PEND_M2M_SRC;
                    n_pend_ch         = r_s1_ch;
                end else if (r_request && r_command[0] && r_s1_ch == CH_W'(1)) begin
                    n_out.kind        = fcdma_pkg::KIND_MEM_WRITE;
                    n_out.bus_address = rec.cur_a;
                    n_out.rdata       = r_temp;
                    n_rec             = count_rec(rec);
                    if (rec.cur_c == 16'h0000)
                        n_status = r_status | (8'h10 << r_s1_ch);
                end else if (r_s1_ch != CH_W'(3) || !r_s1.fdc_request) begin
                    n_out.kind = fcdma_pkg::KIND_NOTHING;
                end else begin
                    case (rec.mode[3:2])
                        fcdma_pkg::MODE_VERIFY: begin
                            // verify: floppy byte dropped, step counted now
                            n_out.kind = fcdma_pkg::KIND_FDC_READ;
                            n_rec      = count_rec(rec);
                            if (rec.cur_c == 16'h0000) begin
                                n_status     = r_status | (8'h10 << r_s1_ch);
                                n_out.fdc_tc = fcdma_pkg::TC_ASSERT;
                            end
                        end
                        fcdma_pkg::MODE_MEM_TO_FDC: begin
                            n_out.kind        = fcdma_pkg::KIND_MEM_READ;
                            n_out.bus_address = rec.cur_a;
                            n_pend            = PEND_MEM2FDC;
                            n_pend_ch         = r_s1_ch;
                        end
                        fcdma_pkg::MODE_FDC_TO_MEM: begin
                            n_out.kind = fcdma_pkg::KIND_FDC_READ;
                            n_pend     = PEND_FDC2MEM;
                            n_pend_ch  = r_s1_ch;
                        end
                        default: n_out.kind = fcdma_pkg::KIND_NOTHING;
                    endcase
                end
            end
            default: begin
                n_pend = PEND_NONE;
                case (r_pend)
                    PEND_M2M_SRC: begin
                        n_temp = r_s1.wdata;
                        if (!r_command[1])
                            n_rec.cur_a = step_addr(rec.cur_a, rec.mode);
                        n_rec.cur_c = rec.cur_c - 16'd1;
                    end
                    PEND_FDC2MEM, PEND_MEM2FDC: begin
                        if (r_pend == PEND_FDC2MEM) begin
                            n_out.kind        = fcdma_pkg::KIND_MEM_WRITE;
                            n_out.bus_address = rec.cur_a;
                        end else begin
                            n_out.kind = fcdma_pkg::KIND_FDC_WRITE;
                        end
                        n_out.rdata = r_s1.wdata;
                        n_rec       = count_rec(rec);
                        if (rec.cur_c == 16'h0000) begin
                            n_status = r_status | (8'h10 << r_s1_ch);
                            if (r_s1_ch == CH_W'(3))
                                n_out.fdc_tc = fcdma_pkg::TC_ASSERT;
                        end
                    end
                    default: n_out.kind = fcdma_pkg::KIND_NOTHING;
                endcase
            end
        endcase
    end

    // channel memory: write-back from the update stage, registered read
    always_ff @(posedge i_clk) begin
        if (s1_fire)
            r_mem[r_s1_ch] <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_rd <= r_mem[rd_ch];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld   <= '0;
            r_fwd_hit   <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_command   <= 8'h00;
            r_status    <= 8'h00;
            r_temp      <= 8'h00;
            r_mask      <= 4'h0;
            r_request   <= 1'b0;
            r_bptr      <= 1'b0;
            r_pend      <= PEND_NONE;
            r_pend_ch   <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1       <= i_data;
                r_s1_ch    <= rd_ch;
                r_rd_ok    <= r_ent_vld[rd_ch];
                // read and write-back of the same channel in one cycle
                r_fwd_hit  <= s1_fire && (r_s1_ch == rd_ch);
                r_fwd      <= n_rec;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_ent_vld[r_s1_ch] <= 1'b1;
                r_command   <= n_command;
                r_status    <= n_status;
                r_temp      <= n_temp;
                r_mask      <= n_mask;
                r_request   <= n_request;
                r_bptr      <= n_bptr;
                r_pend      <= n_pend;
                r_pend_ch   <= n_pend_ch;
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== design/fcdma_checker.sv =====
// port-level checks for the four-channel dma controller
// depends on fcdma_pkg; bound to four_channel_dma_controller below

module fcdma_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input fcdma_pkg::t_in_item  i_data,
    input logic                 o_valid,
    input logic                 i_stall,
    input fcdma_pkg::t_out_item o_data
);

    // no result leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // tc release only comes with a register read
    a_release_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.fdc_tc == fcdma_pkg::TC_RELEASE
        |-> o_data.kind == fcdma_pkg::KIND_READ_DATA)
        else $error("tc release without status read");

    // tc assert only at the end of a floppy transfer
    a_assert_fdc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.fdc_tc == fcdma_pkg::TC_ASSERT
        |-> o_data.kind == fcdma_pkg::KIND_FDC_READ
            || o_data.kind == fcdma_pkg::KIND_FDC_WRITE
            || o_data.kind == fcdma_pkg::KIND_MEM_WRITE)
        else $error("tc assert outside floppy transfer");

    // bus address is zero unless memory is accessed
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind != fcdma_pkg::KIND_MEM_READ
            && o_data.kind != fcdma_pkg::KIND_MEM_WRITE
        |-> o_data.bus_address == 16'h0000)
        else $error("bus address without memory transfer");

endmodule

bind four_channel_dma_controller fcdma_checker u_fcdma_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
